// File: hdl/mlhmq_pkg.sv
// ----------------------------------------------------------------------------
// mlhmq_pkg
// Shared types and constants for the monotone line hull minimum query block.
// ----------------------------------------------------------------------------
package mlhmq_pkg;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [1:0] ADR_TAIL  = 2'd0;
   localparam logic [1:0] ADR_Y     = 2'd1;
   localparam logic [1:0] ADR_X     = 2'd2;
   localparam logic [1:0] ADR_FRONT = 2'd3;

   localparam logic signed [63:0] BP_INF     = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] BP_NEG_INF = 64'sh8000_0000_0000_0001;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      logic [1:0] addr_sel;
      logic       wr_line;
      logic       wr_bp;
      logic       append;
      logic       held_dec;
      logic       succ_clr;
      logic       first_clr;
      logic       y_dec;
      logic       bp_inf;
      logic       bp_eq;
      logic       div_start;
      logic       div_take;
      logic       front_pop;
      logic       mul;
      logic       qadd;
      logic       set_full;
      logic       set_empty;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic held_full;
      logic held_zero;
      logic held_gt1;
      logic first;
      logic succ;
      logic slope_eq;
      logic bp_lt;
      logic bpx_ge_inf;
      logic y_is_one;
      logic front_lt;
      logic div_done;
   } sts_type;

endpackage

// File: hdl/monotone_line_hull_min_query.sv
// ----------------------------------------------------------------------------
// monotone_line_hull_min_query
// Monotone convex hull trick deque answering minimum of k*x+m queries.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_type, slope, intercept, point
// rsp      out        rsp_valid/rsp_ready  min value, status, line count
//
// One item at a time.
// A query pops front lines whose break point lies below the query point.
// An add examines older lines and, per break point, waits on the divider, except
// on equal slopes or at the tail.
// Reset clears the deque pointers; line memories need no clearing pass.
// A finished result waits in the output register while rsp_ready is low.
// ----------------------------------------------------------------------------
module monotone_line_hull_min_query #(
   parameter int HULL_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic signed [31:0] req_line_slope,
   input  logic signed [63:0] req_line_intercept,
   input  logic signed [31:0] req_query_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_min_value,
   output logic [1:0]         rsp_status,
   output logic [10:0]        rsp_line_count
);

   mlhmq_pkg::cmd_type cmd;
   mlhmq_pkg::sts_type sts;

   mlhmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mlhmq_datapath #(
      .HULL_DEPTH (HULL_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_type           (req_type),
      .req_line_slope     (req_line_slope),
      .req_line_intercept (req_line_intercept),
      .req_query_point    (req_query_point),
      .rsp_min_value      (rsp_min_value),
      .rsp_status         (rsp_status),
      .rsp_line_count     (rsp_line_count)
   );

endmodule

// File: hdl/mlhmq_divider.sv
// ----------------------------------------------------------------------------
// mlhmq_divider
// Signed floored 64-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mlhmq_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic signed [63:0] divisor,
   output logic               done,
   output logic [63:0]        quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] ub_ff, ub_in;
   logic        neg_ff, neg_in;
   logic [64:0] shifted;
   logic [64:0] diff;
   logic [63:0] qinc;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ub_in   = ub_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff[63:0], quo_ff[63]};
      diff    = shifted - {1'b0, ub_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rem_in  = 65'd0;
         quo_in  = dividend[63] ? 64'd0 - dividend : dividend;
         ub_in   = divisor[63] ? 64'd0 - divisor : divisor;
         neg_in  = dividend[63] ^ divisor[63];
      end else if (busy_ff) begin
         rem_in = diff[64] ? shifted : diff;
         quo_in = {quo_ff[62:0], ~diff[64]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ub_ff  <= ub_in;
      neg_ff <= neg_in;
   end

   assign qinc     = quo_ff + {63'd0, (rem_ff != 65'd0)};
   assign quotient = neg_ff ? 64'd0 - qinc : quo_ff;
   assign done     = done_ff;

endmodule

// File: hdl/mlhmq_ctrl.sv
// ----------------------------------------------------------------------------
// mlhmq_ctrl
// Sequencer for add pruning and query popping; owns the handshakes.
// ----------------------------------------------------------------------------
module mlhmq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  mlhmq_pkg::sts_type  sts,
   output mlhmq_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DISP = 4'd1;
   localparam logic [3:0] S_RDX  = 4'd2;
   localparam logic [3:0] S_CHK  = 4'd3;
   localparam logic [3:0] S_CMP  = 4'd4;
   localparam logic [3:0] S_DIV  = 4'd5;
   localparam logic [3:0] S_WRBP = 4'd6;
   localparam logic [3:0] S_QRD  = 4'd7;
   localparam logic [3:0] S_QCHK = 4'd8;
   localparam logic [3:0] S_QADD = 4'd9;
   localparam logic [3:0] S_FIN  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       vld_ff, vld_in;

   always_comb begin
      state_in = state_ff;
      vld_in   = vld_ff & ~rsp_ready;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (sts.op == mlhmq_pkg::REQ_ADD) begin
               if (sts.held_full) begin
                  cmd.set_full = 1'b1;
                  state_in     = S_FIN;
               end else begin
                  cmd.append   = 1'b1;
                  cmd.wr_line  = 1'b1;
                  cmd.addr_sel = mlhmq_pkg::ADR_TAIL;
                  state_in     = sts.held_zero ? S_FIN : S_RDX;
               end
            end else begin
               if (sts.held_zero) begin
                  cmd.set_empty = 1'b1;
                  state_in      = S_FIN;
               end else begin
                  state_in = S_QRD;
               end
            end
         end
         S_RDX: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = mlhmq_pkg::ADR_X;
            state_in     = S_CHK;
         end
         S_CHK: begin
            if (sts.first) begin
               state_in = S_CMP;
            end else if (sts.bp_lt) begin
               state_in = S_FIN;
            end else begin
               cmd.held_dec = 1'b1;
               cmd.addr_sel = mlhmq_pkg::ADR_Y;
               if (sts.succ) begin
                  cmd.wr_line = 1'b1;
                  state_in    = S_CMP;
               end else begin
                  cmd.bp_inf = 1'b1;
                  state_in   = S_WRBP;
               end
            end
         end
         S_CMP: begin
            if (sts.slope_eq) begin
               cmd.bp_eq = 1'b1;
               state_in  = S_WRBP;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_WRBP;
            end
         end
         S_WRBP: begin
            cmd.wr_bp     = 1'b1;
            cmd.addr_sel  = mlhmq_pkg::ADR_X;
            cmd.y_dec     = 1'b1;
            cmd.first_clr = 1'b1;
            if (sts.first && sts.bpx_ge_inf) begin
               cmd.held_dec = 1'b1;
               cmd.succ_clr = 1'b1;
            end
            state_in = sts.y_is_one ? S_FIN : S_RDX;
         end
         S_QRD: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = mlhmq_pkg::ADR_FRONT;
            state_in     = S_QCHK;
         end
         S_QCHK: begin
            if (sts.held_gt1 && sts.front_lt) begin
               cmd.front_pop = 1'b1;
               state_in      = S_QRD;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_QADD;
            end
         end
         S_QADD: begin
            cmd.qadd = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!vld_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               vld_in       = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = vld_ff;

endmodule

// File: hdl/mlhmq_datapath.sv
// ----------------------------------------------------------------------------
// mlhmq_datapath
// Line memories, deque pointers, break point math and output register.
// ----------------------------------------------------------------------------
module mlhmq_datapath #(
   parameter int HULL_DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  mlhmq_pkg::cmd_type  cmd,
   output mlhmq_pkg::sts_type  sts,
   input  logic                req_type,
   input  logic signed [31:0]  req_line_slope,
   input  logic signed [63:0]  req_line_intercept,
   input  logic signed [31:0]  req_query_point,
   output logic signed [63:0]  rsp_min_value,
   output logic [1:0]          rsp_status,
   output logic [10:0]         rsp_line_count
);

   localparam int PW = $clog2(HULL_DEPTH);
   localparam int CW = $clog2(HULL_DEPTH + 1);

   logic [32:0] slope_mem [HULL_DEPTH];
   logic [63:0] icpt_mem  [HULL_DEPTH];
   logic [63:0] bp_mem    [HULL_DEPTH];

   logic [PW-1:0]      front_ff, front_in;
   logic [CW-1:0]      held_ff, held_in;
   logic [CW-1:0]      y_ff, y_in;
   logic               first_ff, first_in;
   logic               succ_ff, succ_in;
   logic               op_ff;
   logic signed [32:0] nk_ff;
   logic signed [63:0] nm_ff;
   logic signed [31:0] qx_ff;
   logic signed [63:0] bpx_ff, bpx_in;
   logic signed [63:0] bpy_ff, bpy_in;
   logic signed [32:0] rd_slope_ff;
   logic signed [63:0] rd_icpt_ff;
   logic signed [63:0] rd_bp_ff;
   logic signed [63:0] prod_ff;
   logic signed [64:0] prod_full;
   logic signed [63:0] val_ff, val_in;
   logic [1:0]         st_ff, st_in;
   logic signed [63:0] out_val_ff;
   logic [1:0]         out_st_ff;
   logic [CW-1:0]      out_cnt_ff;
   logic [CW+10:0]     cnt_ext;
   logic [PW-1:0]      addr;
   logic [CW-1:0]      y_m1;
   logic signed [63:0] div_a, div_b;
   logic               div_done;
   logic [63:0]        div_q;

   function automatic logic [PW-1:0] slot(input logic [PW-1:0] fr, input logic [CW-1:0] pos);
      logic [CW:0] sum;
      sum = (CW+1)'(fr) + (CW+1)'(pos);
      if (sum >= (CW+1)'(HULL_DEPTH)) sum = sum - (CW+1)'(HULL_DEPTH);
      return sum[PW-1:0];
   endfunction

   assign y_m1 = y_ff - CW'(1);

   always_comb begin
      unique case (cmd.addr_sel)
         mlhmq_pkg::ADR_TAIL:  addr = slot(front_ff, held_ff);
         mlhmq_pkg::ADR_Y:     addr = slot(front_ff, y_ff);
         mlhmq_pkg::ADR_X:     addr = slot(front_ff, y_m1);
         mlhmq_pkg::ADR_FRONT: addr = front_ff;
         default:              addr = front_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_line) begin
         slope_mem[addr] <= nk_ff;
         icpt_mem[addr]  <= nm_ff;
      end
      if (cmd.wr_line) begin
         bp_mem[addr] <= mlhmq_pkg::BP_INF;
      end else if (cmd.wr_bp) begin
         bp_mem[addr] <= bpx_ff;
      end
      if (cmd.rd_en) begin
         rd_slope_ff <= slope_mem[addr];
         rd_icpt_ff  <= icpt_mem[addr];
         rd_bp_ff    <= bp_mem[addr];
      end
   end

   assign div_a = nm_ff - rd_icpt_ff;
   assign div_b = {{31{rd_slope_ff[32]}}, rd_slope_ff} - {{31{nk_ff[32]}}, nk_ff};

   mlhmq_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   assign prod_full = rd_slope_ff * qx_ff;

   always_comb begin
      front_in = front_ff;
      held_in  = held_ff;
      y_in     = y_ff;
      first_in = first_ff;
      succ_in  = succ_ff;
      bpx_in   = bpx_ff;
      bpy_in   = bpy_ff;
      val_in   = val_ff;
      st_in    = st_ff;
      if (cmd.load) begin
         val_in = 64'sd0;
         st_in  = mlhmq_pkg::ST_OK;
      end
      if (cmd.set_full)  st_in = mlhmq_pkg::ST_FULL;
      if (cmd.set_empty) st_in = mlhmq_pkg::ST_EMPTY;
      if (cmd.append) begin
         y_in     = held_ff;
         held_in  = held_ff + CW'(1);
         first_in = 1'b1;
         succ_in  = 1'b1;
      end
      if (cmd.held_dec) held_in = held_ff - CW'(1);
      if (cmd.succ_clr) succ_in = 1'b0;
      if (cmd.first_clr) first_in = 1'b0;
      if (cmd.y_dec) begin
         y_in   = y_m1;
         bpy_in = bpx_ff;
      end
      if (cmd.bp_inf) bpx_in = mlhmq_pkg::BP_INF;
      if (cmd.bp_eq) begin
         bpx_in = (rd_icpt_ff > nm_ff) ? mlhmq_pkg::BP_INF : mlhmq_pkg::BP_NEG_INF;
      end
      if (cmd.div_take) bpx_in = div_q;
      if (cmd.front_pop) begin
         front_in = slot(front_ff, CW'(1));
         held_in  = held_ff - CW'(1);
      end
      if (cmd.qadd) val_in = 64'sd0 - (prod_ff + rd_icpt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         held_ff  <= '0;
      end else begin
         front_ff <= front_in;
         held_ff  <= held_in;
      end
      y_ff     <= y_in;
      first_ff <= first_in;
      succ_ff  <= succ_in;
      bpx_ff   <= bpx_in;
      bpy_ff   <= bpy_in;
      val_ff   <= val_in;
      st_ff    <= st_in;
      if (cmd.load) begin
         op_ff <= req_type;
         nk_ff <= 33'sd0 - {req_line_slope[31], req_line_slope};
         nm_ff <= 64'sd0 - req_line_intercept;
         qx_ff <= req_query_point;
      end
      if (cmd.mul) prod_ff <= prod_full[63:0];
      if (cmd.out_load) begin
         out_val_ff <= val_ff;
         out_st_ff  <= st_ff;
         out_cnt_ff <= held_ff;
      end
   end

   assign sts.op         = op_ff;
   assign sts.held_full  = (held_ff == CW'(HULL_DEPTH));
   assign sts.held_zero  = (held_ff == '0);
   assign sts.held_gt1   = (held_ff > CW'(1));
   assign sts.first      = first_ff;
   assign sts.succ       = succ_ff;
   assign sts.slope_eq   = (rd_slope_ff == nk_ff);
   assign sts.bp_lt      = (rd_bp_ff < bpy_ff);
   assign sts.bpx_ge_inf = (bpx_ff >= mlhmq_pkg::BP_INF);
   assign sts.y_is_one   = (y_ff == CW'(1));
   assign sts.front_lt   = (rd_bp_ff < $signed({{32{qx_ff[31]}}, qx_ff}));
   assign sts.div_done   = div_done;

   assign cnt_ext        = {11'd0, out_cnt_ff};
   assign rsp_min_value  = out_val_ff;
   assign rsp_status     = out_st_ff;
   assign rsp_line_count = cnt_ext[10:0];

endmodule
